// ===== hdl/istadd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// istadd_pkg
// Shared types, constants and the sine table of the interpolated tone adder.
// ============================================================================
package istadd_pkg;

    localparam int SampleWidth  = 16;
    localparam int PhaseWidth   = 15;
    localparam int PointBits    = 7;
    localparam int FracBits     = 8;
    localparam int CfgIndexBits = 1;
    localparam int CfgDataBits  = 16;

    localparam logic [31:0] STEP_SCALE = 32'd16777;
    localparam logic [31:0] STEP_ROUND = 32'd2048;

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_AMPLITUDE = 1'b0,
        CFG_FREQUENCY = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INTERP,
        ST_SCALE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic do_interp;
        logic do_scale;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

    localparam logic [15:0] SINE_Q14 [128] = '{
        16'h0000, 16'h0324, 16'h0646, 16'h0964, 16'h0c7c, 16'h0f8d, 16'h1294, 16'h1590,
        16'h187e, 16'h1b5d, 16'h1e2b, 16'h20e7, 16'h238e, 16'h2620, 16'h289a, 16'h2afb,
        16'h2d41, 16'h2f6c, 16'h3179, 16'h3368, 16'h3537, 16'h36e5, 16'h3871, 16'h39db,
        16'h3b21, 16'h3c42, 16'h3d3f, 16'h3e15, 16'h3ec5, 16'h3f4f, 16'h3fb1, 16'h3fec,
        16'h4000, 16'h3fec, 16'h3fb1, 16'h3f4f, 16'h3ec5, 16'h3e15, 16'h3d3f, 16'h3c42,
        16'h3b21, 16'h39db, 16'h3871, 16'h36e5, 16'h3537, 16'h3368, 16'h3179, 16'h2f6c,
        16'h2d41, 16'h2afb, 16'h289a, 16'h2620, 16'h238e, 16'h20e7, 16'h1e2b, 16'h1b5d,
        16'h187e, 16'h1590, 16'h1294, 16'h0f8d, 16'h0c7c, 16'h0964, 16'h0646, 16'h0324,
        16'h0000, 16'hfcdc, 16'hf9ba, 16'hf69c, 16'hf384, 16'hf073, 16'hed6c, 16'hea70,
        16'he782, 16'he4a3, 16'he1d5, 16'hdf19, 16'hdc72, 16'hd9e0, 16'hd766, 16'hd505,
        16'hd2bf, 16'hd094, 16'hce87, 16'hcc98, 16'hcac9, 16'hc91b, 16'hc78f, 16'hc625,
        16'hc4df, 16'hc3be, 16'hc2c1, 16'hc1eb, 16'hc13b, 16'hc0b1, 16'hc04f, 16'hc014,
        16'hc000, 16'hc014, 16'hc04f, 16'hc0b1, 16'hc13b, 16'hc1eb, 16'hc2c1, 16'hc3be,
        16'hc4df, 16'hc625, 16'hc78f, 16'hc91b, 16'hcac9, 16'hcc98, 16'hce87, 16'hd094,
        16'hd2bf, 16'hd505, 16'hd766, 16'hd9e0, 16'hdc72, 16'hdf19, 16'he1d5, 16'he4a3,
        16'he782, 16'hea70, 16'hed6c, 16'hf073, 16'hf384, 16'hf69c, 16'hf9ba, 16'hfcdc
    };

endpackage

// ===== hdl/istadd_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// istadd_ctrl
// Sequencer that steps one word through lookup, interpolation and scaling.
// ============================================================================
module istadd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  istadd_pkg::t_dp_status i_status,
    output istadd_pkg::t_dp_cmd   o_cmd
);

    istadd_pkg::t_state r_state;
    istadd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= istadd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            istadd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = istadd_pkg::ST_INTERP;
                end
            end
            istadd_pkg::ST_INTERP: begin
                n_state = istadd_pkg::ST_SCALE;
            end
            istadd_pkg::ST_SCALE: begin
                if (!i_status.out_busy) begin
                    n_state = istadd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = istadd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall        = 1'b1;
        o_cmd.load_in     = 1'b0;
        o_cmd.do_interp   = 1'b0;
        o_cmd.do_scale    = 1'b0;
        unique case (r_state)
            istadd_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            istadd_pkg::ST_INTERP: begin
                o_cmd.do_interp = 1'b1;
            end
            istadd_pkg::ST_SCALE: begin
                o_cmd.do_scale = !i_status.out_busy;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/istadd_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// istadd_dp
// Datapath: settings, phase accumulator, table lookup, shared multiplier and
// output register.
// ============================================================================
module istadd_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [istadd_pkg::CfgIndexBits-1:0]  i_cfg_index,
    input  logic [istadd_pkg::CfgDataBits-1:0]   i_cfg_data,
    input  logic signed [istadd_pkg::SampleWidth-1:0] i_sample_in,
    input  logic                                 i_last_in,
    input  istadd_pkg::t_dp_cmd                  i_cmd,
    output istadd_pkg::t_dp_status               o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [istadd_pkg::SampleWidth-1:0] o_sample_out,
    output logic                                 o_last_out
);

    logic [15:0]                             r_amplitude;
    logic [15:0]                             r_frequency;
    logic [istadd_pkg::PhaseWidth-1:0]       r_phase;
    logic signed [15:0]                      r_sample;
    logic                                    r_last;
    logic signed [15:0]                      r_base;
    logic signed [16:0]                      r_slope;
    logic [istadd_pkg::FracBits-1:0]         r_frac;
    logic signed [17:0]                      r_interp;
    logic                                    r_out_valid;
    logic signed [15:0]                      r_sample_out;
    logic                                    r_last_out;

    logic [istadd_pkg::PointBits-1:0]        w_pt;
    logic [istadd_pkg::PointBits-1:0]        w_pt_next;
    logic signed [15:0]                      w_base;
    logic signed [15:0]                      w_next;
    logic signed [17:0]                      w_mul_a;
    logic signed [16:0]                      w_mul_b;
    logic signed [34:0]                      w_prod;
    logic [31:0]                             w_step_full;
    logic [istadd_pkg::PhaseWidth-1:0]       w_step;

    assign w_pt      = r_phase[14:8];
    assign w_pt_next = w_pt + 7'd1;
    assign w_base    = istadd_pkg::SINE_Q14[w_pt];
    assign w_next    = istadd_pkg::SINE_Q14[w_pt_next];

    // One multiplier serves both the interpolation and the amplitude scaling.
    always_comb begin
        if (i_cmd.do_interp) begin
            w_mul_a = {r_slope[16], r_slope};
            w_mul_b = {9'd0, r_frac};
        end else begin
            w_mul_a = r_interp;
            w_mul_b = {1'b0, r_amplitude};
        end
    end

    assign w_prod      = w_mul_a * w_mul_b;
    assign w_step_full = ({16'd0, r_frequency} * istadd_pkg::STEP_SCALE) + istadd_pkg::STEP_ROUND;
    assign w_step      = w_step_full[26:12];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= '0;
            r_frequency <= '0;
        end else if (i_cfg_we) begin
            unique case (istadd_pkg::t_cfg_index'(i_cfg_index))
                istadd_pkg::CFG_AMPLITUDE: r_amplitude <= i_cfg_data;
                istadd_pkg::CFG_FREQUENCY: r_frequency <= i_cfg_data;
                default: r_amplitude <= r_amplitude;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_interp) begin
                r_phase <= r_phase + w_step;
            end
            if (i_cmd.do_scale) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample_in;
            r_last   <= i_last_in;
            r_base   <= w_base;
            r_slope  <= 17'(w_next) - 17'(w_base);
            r_frac   <= r_phase[istadd_pkg::FracBits-1:0];
        end
        if (i_cmd.do_interp) begin
            r_interp <= {{2{r_base[15]}}, r_base} + w_prod[25:8];
        end
        if (i_cmd.do_scale) begin
            r_sample_out <= r_sample + w_prod[29:14];
            r_last_out   <= r_last;
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_sample_out;
    assign o_last_out        = r_last_out;

endmodule

// ===== hdl/interpolated_sine_tone_adder_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// interpolated_sine_tone_adder_unit
// Adds a linearly interpolated sine tone to a stream of 16-bit samples.
// ============================================================================
// For each word the two sine points for the current phase are read when
// the word is loaded, then the interpolation multiply and phase advance run,
// then the amplitude multiply and the add; both multiplies run on one shared
// multiplier. A new word is taken once the previous one has moved to the
// output register, so the result may wait there while the next word is
// processed. The user must write amplitude and frequency through the register
// port only while the block is idle; the block itself does not enforce this.
module interpolated_sine_tone_adder_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [istadd_pkg::CfgIndexBits-1:0]  i_cfg_index,
    input  logic [istadd_pkg::CfgDataBits-1:0]   i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [istadd_pkg::SampleWidth-1:0] i_sample_in,
    input  logic                                 i_last_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [istadd_pkg::SampleWidth-1:0] o_sample_out,
    output logic                                 o_last_out
);

    istadd_pkg::t_dp_cmd    w_cmd;
    istadd_pkg::t_dp_status w_status;

    istadd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    istadd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_last_in    (i_last_in),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Block accepted a word while the previous one was in flight.");

    a_busy_two_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> ##2 o_in_stall)
        else $error("Block left the scaling step too early.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("Result appeared without a word being processed.");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the interpolated sine tone adder.
// ============================================================================
// Words go in through the valid/stall handshake. A bit-accurate model of the
// phase accumulator, the table interpolation and the amplitude scaling
// predicts each output word. The checker compares every accepted output word
// with the oldest prediction. Directed words cover the sample extremes,
// wrapping at large amplitude and large frequency, and the buffer flag.
// Random tones follow, with random gaps on both sides, one long hold-off at
// the output, and register writes only while the block is empty.
// ============================================================================
module tb_top;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PRINT_LIMIT  = 40;

    localparam logic [15:0] SINE_PTS [128] = '{
        16'h0000, 16'h0324, 16'h0646, 16'h0964, 16'h0c7c, 16'h0f8d, 16'h1294, 16'h1590,
        16'h187e, 16'h1b5d, 16'h1e2b, 16'h20e7, 16'h238e, 16'h2620, 16'h289a, 16'h2afb,
        16'h2d41, 16'h2f6c, 16'h3179, 16'h3368, 16'h3537, 16'h36e5, 16'h3871, 16'h39db,
        16'h3b21, 16'h3c42, 16'h3d3f, 16'h3e15, 16'h3ec5, 16'h3f4f, 16'h3fb1, 16'h3fec,
        16'h4000, 16'h3fec, 16'h3fb1, 16'h3f4f, 16'h3ec5, 16'h3e15, 16'h3d3f, 16'h3c42,
        16'h3b21, 16'h39db, 16'h3871, 16'h36e5, 16'h3537, 16'h3368, 16'h3179, 16'h2f6c,
        16'h2d41, 16'h2afb, 16'h289a, 16'h2620, 16'h238e, 16'h20e7, 16'h1e2b, 16'h1b5d,
        16'h187e, 16'h1590, 16'h1294, 16'h0f8d, 16'h0c7c, 16'h0964, 16'h0646, 16'h0324,
        16'h0000, 16'hfcdc, 16'hf9ba, 16'hf69c, 16'hf384, 16'hf073, 16'hed6c, 16'hea70,
        16'he782, 16'he4a3, 16'he1d5, 16'hdf19, 16'hdc72, 16'hd9e0, 16'hd766, 16'hd505,
        16'hd2bf, 16'hd094, 16'hce87, 16'hcc98, 16'hcac9, 16'hc91b, 16'hc78f, 16'hc625,
        16'hc4df, 16'hc3be, 16'hc2c1, 16'hc1eb, 16'hc13b, 16'hc0b1, 16'hc04f, 16'hc014,
        16'hc000, 16'hc014, 16'hc04f, 16'hc0b1, 16'hc13b, 16'hc1eb, 16'hc2c1, 16'hc3be,
        16'hc4df, 16'hc625, 16'hc78f, 16'hc91b, 16'hcac9, 16'hcc98, 16'hce87, 16'hd094,
        16'hd2bf, 16'hd505, 16'hd766, 16'hd9e0, 16'hdc72, 16'hdf19, 16'he1d5, 16'he4a3,
        16'he782, 16'hea70, 16'hed6c, 16'hf073, 16'hf384, 16'hf69c, 16'hf9ba, 16'hfcdc
    };

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } t_mix_word;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    istadd_pkg::t_cfg_index       cfg_index = istadd_pkg::CFG_AMPLITUDE;
    logic [istadd_pkg::CfgDataBits-1:0] cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic signed [istadd_pkg::SampleWidth-1:0] sample_in = '0;
    logic                         last_in = 1'b0;
    logic                         out_stall = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic signed [istadd_pkg::SampleWidth-1:0] sample_out;
    logic                         last_out;

    logic [14:0] tone_phase = '0;
    logic [15:0] tone_amp = '0;
    logic [15:0] tone_freq = '0;
    t_mix_word   pending_mix[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          idle_en = 1'b1;
    int          long_hold = 0;

    interpolated_sine_tone_adder_unit dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_sample_in  (sample_in),
        .i_last_in    (last_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_sample_out (sample_out),
        .o_last_out   (last_out)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Works out the output word for one sample and advances the phase.
    function automatic t_mix_word mix_tone(input logic [15:0] s, input logic l);
        logic [6:0]  pt;
        logic [6:0]  pt_next;
        logic [11:0] frac;
        longint      base_val;
        longint      next_val;
        longint      slope;
        longint      interp;
        longint      scaled;
        logic [31:0] step;
        t_mix_word   w;
        pt       = tone_phase[14:8];
        pt_next  = pt + 7'd1;
        frac     = {tone_phase[7:0], 4'h0};
        base_val = $signed(SINE_PTS[pt]);
        next_val = $signed(SINE_PTS[pt_next]);
        slope    = next_val - base_val;
        interp   = base_val + ((slope * longint'(frac)) >>> 12);
        scaled   = (interp * longint'(tone_amp)) >>> 14;
        w.sample = s + scaled[15:0];
        w.last   = l;
        step       = (32'(tone_freq) * 32'd16777 + 32'd2048) >> 12;
        tone_phase = tone_phase + step[14:0];
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("Mismatch at cycle %0d: %s", cycles, msg);
        end
    endtask

    task automatic send_word(input logic [15:0] s, input logic l);
        int gap;
        gap = idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        last_in   <= l;
        do @(posedge clk); while (in_stall);
        pending_mix.push_back(mix_tone(s, l));
    endtask

    task automatic write_reg(input istadd_pkg::t_cfg_index idx, input logic [15:0] val);
        in_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == istadd_pkg::CFG_AMPLITUDE) begin
            tone_amp = val;
        end else begin
            tone_freq = val;
        end
    endtask

    task automatic set_tone(input logic [15:0] amp, input logic [15:0] freq);
        write_reg(istadd_pkg::CFG_AMPLITUDE, amp);
        write_reg(istadd_pkg::CFG_FREQUENCY, freq);
    endtask

    task automatic test_zero_tone();
        set_tone(16'h0000, 16'h0000);
        send_word(16'h7fff, 1'b1);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);
    endtask

    task automatic test_sample_extremes();
        set_tone(16'h4000, 16'd1000);
        send_word(16'h7fff, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'hffff, 1'b1);
        send_word(16'h0001, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'haaaa, 1'b1);
    endtask

    task automatic test_large_amplitude();
        set_tone(16'hffff, 16'd2000);
        repeat (6) send_word(16'($urandom), 1'b0);
    endtask

    task automatic test_large_frequency();
        set_tone(16'h7fff, 16'hffff);
        repeat (5) send_word(16'($urandom), 1'b0);
    endtask

    task automatic test_buffer_flags();
        set_tone(16'h4000, 16'd1);
        send_word(16'h1234, 1'b0);
        send_word(16'h8765, 1'b0);
        send_word(16'h0f0f, 1'b1);
        send_word(16'hf0f0, 1'b0);
        send_word(16'h0000, 1'b1);
    endtask

    task automatic test_backpressure();
        set_tone(16'h2000, 16'd440);
        idle_en   = 1'b0;
        long_hold = 100;
        repeat (40) send_word(16'($urandom), ($urandom_range(0, 15) == 0));
        idle_en = 1'b1;
    endtask

    task automatic test_random_tones();
        logic [15:0] amp;
        logic [15:0] freq;
        for (int p = 0; p < 8; p++) begin
            amp  = 16'($urandom);
            freq = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, 4000));
            if (p == 0) begin
                amp  = 16'hffff;
                freq = 16'hffff;
            end
            set_tone(amp, freq);
            idle_en = (p % 3 != 2);
            repeat (145) send_word(16'($urandom), ($urandom_range(0, 15) == 0));
        end
        idle_en = 1'b1;
    endtask

    initial begin : out_stall_ctl
        int n;
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold > 0) begin
                n = long_hold;
                long_hold = 0;
            end else begin
                n = idle_en ? $urandom_range(0, 5) : 0;
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin : mix_checker
        t_mix_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_mix.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h last %b",
                                          sample_out, last_out));
            end else begin
                want = pending_mix.pop_front();
                if (sample_out !== want.sample) begin
                    report_mismatch($sformatf("sample %h, expected %h",
                                              sample_out, want.sample));
                end
                if (last_out !== want.last) begin
                    report_mismatch($sformatf("last %b, expected %b",
                                              last_out, want.last));
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_tone();
        test_sample_extremes();
        test_large_amplitude();
        test_large_frequency();
        test_buffer_flags();
        test_backpressure();
        test_random_tones();
        in_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
